[hw/rtl/icf_pkg.sv]
// Shared constants, types and the saturation helper function of the image convolution filter.
package icf_pkg;

    localparam int MAX_RADIUS   = 2;
    localparam int KSIDE        = 2 * MAX_RADIUS + 1;
    localparam int KSIZE        = KSIDE * KSIDE;
    localparam int KIDX_BITS    = $clog2(KSIZE);
    localparam int TAP_BITS     = $clog2(KSIDE);
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT   = 4096;
    localparam int STORE_ROWS   = KSIDE;
    localparam int ROW_SEL_BITS = $clog2(STORE_ROWS);
    localparam int ADDR_BITS    = ROW_SEL_BITS + COL_BITS;
    localparam int MEM_DEPTH    = STORE_ROWS * MAX_WIDTH;
    localparam int COEF_BITS    = 16;
    localparam int PIX_BITS     = 24;
    localparam int PROD_BITS    = COEF_BITS + 9;
    localparam int SUM_BITS     = COEF_BITS + 5;
    localparam int ACC_BITS     = PROD_BITS + 4;

    typedef enum logic [1:0] {
        OP_COEF  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_THREE  = 2'd3;

    // Clamp a signed filter result into the 8-bit pixel range.
    function automatic logic [7:0] sat8(input logic signed [ACC_BITS-1:0] v);
        logic [7:0] r;
        if (v[ACC_BITS-1])
            r = 8'd0;
        else if (v > $signed(ACC_BITS'(255)))
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

[hw/rtl/icf_div.sv]
// Serial signed divider, one quotient bit per cycle while busy, truncating toward zero.
module icf_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [icf_pkg::ACC_BITS-1:0]  dividend,
    input  logic signed [icf_pkg::SUM_BITS-1:0]  divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [icf_pkg::ACC_BITS-1:0]  quotient
);
    localparam int AB = icf_pkg::ACC_BITS;
    localparam int SB = icf_pkg::SUM_BITS;
    localparam int CNT_BITS = $clog2(AB);

    logic                busy_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [AB-1:0]       dvd_reg;
    logic [SB:0]         rem_reg;
    logic [SB:0]         dsr_reg;
    logic [SB:0]         trial;
    logic                qbit;
    logic [SB:0]         rem_next;

    always_comb
    begin
        trial    = {rem_reg[SB-1:0], dvd_reg[AB-1]};
        qbit     = (trial >= dsr_reg);
        rem_next = qbit ? (trial - dsr_reg) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                neg_reg  <= dividend[AB-1] ^ divisor[SB-1];
                dvd_reg  <= dividend[AB-1] ? AB'(-dividend) : AB'(dividend);
                dsr_reg  <= divisor[SB-1] ? (SB+1)'(-$signed({divisor[SB-1], divisor}))
                                          : {1'b0, divisor};
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[AB-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(AB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule

[hw/rtl/image_convolution_filter_top.sv]
// Top level of the streaming normalized square-kernel image convolution filter.
// A pixel transfer without a result passes the decision states S_CMP0 to S_CMP2; a coefficient load
// or radius change runs a kernel sum sweep over 9 or 25 entries, one table entry per cycle.
// After a flush transfer a result sets out_valid after the center read, one line store read per tap,
// the drain of the multiply-accumulate pipeline, a divide per channel and the bookkeeping states.
// A pixel transfer that yields a result, other than the last of a frame, passes the decision states first.
// With a zero kernel sum the divide is skipped and each accumulator is saturated directly.
// Reset clears the counters, kernel table and kernel sum at once; the line store is not cleared.
module image_convolution_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [12:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [4:0]                          coef_index,
    input  logic signed [15:0]                  coef_value,
    input  logic [7:0]                          pix_c0,
    input  logic [7:0]                          pix_c1,
    input  logic [7:0]                          pix_c2,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_c0,
    output logic [7:0]                          out_c1,
    output logic [7:0]                          out_c2,
    output logic                                frame_last
);
    localparam int AB = icf_pkg::ACC_BITS;
    localparam int SB = icf_pkg::SUM_BITS;
    localparam int KB = icf_pkg::KIDX_BITS;
    localparam int TB = icf_pkg::TAP_BITS;
    localparam int CB = icf_pkg::COL_BITS;
    localparam int RB = icf_pkg::ROW_SEL_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_CMP0, S_CMP1, S_CMP2, S_CENTER, S_TAPS, S_DRAIN,
        S_DIV, S_DIVW, S_LAST0, S_LAST1, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [1:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        three_reg;
    logic        sum_pend_reg;

    // Kernel table and its running sum.
    logic signed [icf_pkg::COEF_BITS-1:0] ktab_reg [icf_pkg::KSIZE];
    logic signed [icf_pkg::SUM_BITS-1:0]  ksum_reg;
    logic [KB-1:0]                        sum_i_reg;

    // Raster position counters, with row counters modulo the number of stored rows.
    logic [12:0]   in_row_reg;
    logic [CB-1:0] in_col_reg;
    logic [RB-1:0] in_mod_reg;
    logic [11:0]   out_row_reg;
    logic [CB-1:0] out_col_reg;
    logic [RB-1:0] out_mod_reg;
    logic          in_done_reg;

    // Emission bookkeeping.
    logic [23:0] prod_a_reg;
    logic [23:0] prod_b_reg;
    logic [24:0] lhs_reg;
    logic [24:0] rhs_reg;
    logic        last_reg;

    // Neighborhood walk and multiply-accumulate pipeline.
    logic [TB-1:0]                        ta_reg;
    logic [TB-1:0]                        tb_reg;
    logic [KB-1:0]                        tk_reg;
    logic                                 cen_pend_reg;
    logic [icf_pkg::PIX_BITS-1:0]         cen_reg;
    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 in1_reg;
    logic signed [icf_pkg::COEF_BITS-1:0] coef1_reg;
    logic signed [icf_pkg::PROD_BITS-1:0] prod_reg [3];
    logic signed [AB-1:0]                 acc_reg [3];
    logic [1:0]                           ch_reg;
    logic [7:0]                           res_reg [3];

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_c0_reg;
    logic [7:0] out_c1_reg;
    logic [7:0] out_c2_reg;
    logic       frame_last_reg;

    // Line store.
    logic [icf_pkg::PIX_BITS-1:0]  mem [icf_pkg::MEM_DEPTH];
    logic [icf_pkg::PIX_BITS-1:0]  rdata_reg;
    logic                          mem_we;
    logic [icf_pkg::ADDR_BITS-1:0] waddr;
    logic [icf_pkg::PIX_BITS-1:0]  wdata;
    logic                          mem_re;
    logic [icf_pkg::ADDR_BITS-1:0] raddr_next;

    // Derived sizes, with out-of-range register values clamped.
    logic [1:0]    eff_r;
    logic [10:0]   eff_w;
    logic [12:0]   eff_h;
    logic [2:0]    side;
    logic [KB-1:0] ksq;
    logic [11:0]   rw;

    logic                         in_fire;
    logic                         pix_store;
    logic                         in_wrap;
    logic                         in_fin;
    logic                         out_load;
    logic signed [13:0]           nr;
    logic signed [11:0]           nc;
    logic signed [3:0]            rm_raw;
    logic [RB-1:0]                rm;
    logic                         inframe;
    logic                         tap_end;
    logic [KB-1:0]                kidx;
    logic signed [icf_pkg::COEF_BITS-1:0] kval;
    logic [icf_pkg::PIX_BITS-1:0] px1;
    logic [RB-1:0]                in_mod_inc;
    logic [RB-1:0]                out_mod_inc;

    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic signed [AB-1:0] div_q;

    always_comb
    begin
        if (radius_reg == 2'd0)
            eff_r = 2'd1;
        else if (radius_reg > 2'(icf_pkg::MAX_RADIUS))
            eff_r = 2'(icf_pkg::MAX_RADIUS);
        else
            eff_r = radius_reg;
        if (width_reg == 11'd0)
            eff_w = 11'd1;
        else if (width_reg > 11'(icf_pkg::MAX_WIDTH))
            eff_w = 11'(icf_pkg::MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == 13'd0)
            eff_h = 13'd1;
        else if (height_reg > 13'(icf_pkg::MAX_HEIGHT))
            eff_h = 13'(icf_pkg::MAX_HEIGHT);
        else
            eff_h = height_reg;
        side  = {eff_r, 1'b1};
        ksq   = KB'(side * side);
        rw    = (eff_r == 2'd2) ? {eff_w, 1'b0} : {1'b0, eff_w};
    end

    // The input side takes a transfer only when the sequencer is idle and no kernel sum sweep is pending.
    assign in_ready  = (state_reg == S_IDLE) && !sum_pend_reg;
    assign in_fire   = in_valid && in_ready;
    assign pix_store = in_fire && (op == icf_pkg::OP_PIXEL) && !in_done_reg
                       && (in_row_reg < eff_h);
    assign in_wrap   = (11'(in_col_reg) + 11'd1) >= eff_w;
    assign in_fin    = in_wrap && ((in_row_reg + 13'd1) >= eff_h);
    assign in_mod_inc  = (in_mod_reg == RB'(icf_pkg::STORE_ROWS - 1)) ? '0 : in_mod_reg + 1'b1;
    assign out_mod_inc = (out_mod_reg == RB'(icf_pkg::STORE_ROWS - 1)) ? '0 : out_mod_reg + 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign mem_we = pix_store;
    assign waddr  = {in_mod_reg, in_col_reg};
    assign wdata  = three_reg ? {pix_c2, pix_c1, pix_c0} : {16'd0, pix_c0};

    // Position of the current neighbor and its line store row.
    always_comb
    begin
        nr = $signed(14'(out_row_reg)) + $signed(14'(ta_reg)) - $signed(14'(eff_r));
        nc = $signed(12'(out_col_reg)) + $signed(12'(tb_reg)) - $signed(12'(eff_r));
        rm_raw = $signed(4'(out_mod_reg)) + $signed(4'(ta_reg)) - $signed(4'(eff_r));
        if (rm_raw < 0)
            rm = RB'(rm_raw + 4'(icf_pkg::STORE_ROWS));
        else if (rm_raw >= 4'(icf_pkg::STORE_ROWS))
            rm = RB'(rm_raw - 4'(icf_pkg::STORE_ROWS));
        else
            rm = RB'(rm_raw);
        inframe = !nr[13] && (nr[12:0] < eff_h) && !nc[11] && (nc[10:0] < eff_w);
        tap_end = (ta_reg == TB'(side - 3'd1)) && (tb_reg == TB'(side - 3'd1));
        kidx    = (state_reg == S_SUM) ? sum_i_reg : tk_reg;
        kval    = ktab_reg[kidx];
        mem_re  = (state_reg == S_CENTER) || (state_reg == S_TAPS);
        if (state_reg == S_CENTER)
            raddr_next = {out_mod_reg, out_col_reg};
        else
            raddr_next = {rm, nc[CB-1:0]};
        px1 = in1_reg ? rdata_reg : cen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= mem[raddr_next];
    end

    assign div_start = (state_reg == S_DIV) && (ksum_reg != '0);

    icf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[ch_reg]),
        .divisor  (ksum_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer: coefficient loads, pixel stores, emission decisions and the filter itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= 2'd1;
            width_reg     <= 11'd1024;
            height_reg    <= 13'd1024;
            three_reg     <= 1'b1;
            sum_pend_reg  <= 1'b0;
            for (int i = 0; i < icf_pkg::KSIZE; i++)
                ktab_reg[i] <= '0;
            ksum_reg      <= '0;
            sum_i_reg     <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_mod_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_mod_reg   <= '0;
            in_done_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            cen_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The multiply-accumulate pipeline runs behind the neighbor walk.
            v1_reg       <= (state_reg == S_TAPS);
            v2_reg       <= v1_reg;
            cen_pend_reg <= (state_reg == S_CENTER);
            if (cen_pend_reg)
                cen_reg <= rdata_reg;
            if (v1_reg)
            begin
                for (int p = 0; p < 3; p++)
                    prod_reg[p] <= coef1_reg * $signed({1'b0, px1[8*p +: 8]});
            end
            if (v2_reg)
            begin
                for (int p = 0; p < 3; p++)
                    acc_reg[p] <= acc_reg[p] + AB'(prod_reg[p]);
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sum_pend_reg)
                    begin
                        sum_pend_reg <= 1'b0;
                        ksum_reg     <= '0;
                        sum_i_reg    <= '0;
                        state_reg    <= S_SUM;
                    end
                    else if (in_fire)
                    begin
                        case (op)
                            icf_pkg::OP_COEF:
                            begin
                                if (coef_index < ksq)
                                begin
                                    ktab_reg[coef_index[KB-1:0]] <= coef_value;
                                    ksum_reg  <= '0;
                                    sum_i_reg <= '0;
                                    state_reg <= S_SUM;
                                end
                            end
                            icf_pkg::OP_PIXEL:
                            begin
                                if (!in_done_reg && (in_row_reg >= eff_h))
                                    in_done_reg <= 1'b1;
                                else if (pix_store)
                                begin
                                    if (in_wrap)
                                    begin
                                        in_col_reg <= '0;
                                        in_row_reg <= in_row_reg + 13'd1;
                                        in_mod_reg <= in_mod_inc;
                                    end
                                    else
                                        in_col_reg <= in_col_reg + 1'b1;
                                    if (in_fin)
                                    begin
                                        in_done_reg <= 1'b1;
                                        state_reg   <= S_CENTER;
                                    end
                                    else
                                        state_reg <= S_CMP0;
                                end
                            end
                            icf_pkg::OP_FLUSH:
                            begin
                                if (in_done_reg)
                                    state_reg <= S_CENTER;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SUM:
                begin
                    ksum_reg  <= ksum_reg + SB'(kval);
                    sum_i_reg <= sum_i_reg + 1'b1;
                    if (sum_i_reg == ksq - 1'b1)
                        state_reg <= S_IDLE;
                end
                S_CMP0:
                begin
                    prod_a_reg <= 24'(in_row_reg * eff_w);
                    prod_b_reg <= 24'(out_row_reg * eff_w);
                    state_reg  <= S_CMP1;
                end
                S_CMP1:
                begin
                    lhs_reg   <= 25'(prod_a_reg) + 25'(in_col_reg);
                    rhs_reg   <= 25'(prod_b_reg) + 25'(out_col_reg) + 25'(rw) + 25'(eff_r);
                    state_reg <= S_CMP2;
                end
                S_CMP2:
                begin
                    state_reg <= (lhs_reg > rhs_reg) ? S_CENTER : S_IDLE;
                end
                S_CENTER:
                begin
                    ta_reg <= '0;
                    tb_reg <= '0;
                    tk_reg <= '0;
                    for (int p = 0; p < 3; p++)
                        acc_reg[p] <= '0;
                    state_reg <= S_TAPS;
                end
                S_TAPS:
                begin
                    in1_reg   <= inframe;
                    coef1_reg <= kval;
                    tk_reg    <= tk_reg + 1'b1;
                    if (TB'(tb_reg + 1'b1) == TB'(side))
                    begin
                        tb_reg <= '0;
                        ta_reg <= ta_reg + 1'b1;
                    end
                    else
                        tb_reg <= tb_reg + 1'b1;
                    if (tap_end)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    ch_reg <= 2'd0;
                    if (!v1_reg && !v2_reg)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (ksum_reg == '0)
                    begin
                        res_reg[ch_reg] <= icf_pkg::sat8(acc_reg[ch_reg]);
                        ch_reg          <= ch_reg + 1'b1;
                        if (ch_reg == 2'd2)
                            state_reg <= S_LAST0;
                    end
                    else
                        state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        res_reg[ch_reg] <= icf_pkg::sat8(div_q);
                        ch_reg          <= ch_reg + 1'b1;
                        state_reg       <= (ch_reg == 2'd2) ? S_LAST0 : S_DIV;
                    end
                end
                S_LAST0:
                begin
                    prod_a_reg <= 24'(out_row_reg * eff_w);
                    prod_b_reg <= 24'(eff_w * eff_h);
                    state_reg  <= S_LAST1;
                end
                S_LAST1:
                begin
                    last_reg  <= (25'(prod_a_reg) + 25'(out_col_reg) + 25'd1) >= 25'(prod_b_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_c0_reg     <= res_reg[0];
                        out_c1_reg     <= three_reg ? res_reg[1] : 8'd0;
                        out_c2_reg     <= three_reg ? res_reg[2] : 8'd0;
                        frame_last_reg <= last_reg;
                        if (last_reg)
                        begin
                            in_row_reg  <= '0;
                            in_col_reg  <= '0;
                            in_mod_reg  <= '0;
                            out_row_reg <= '0;
                            out_col_reg <= '0;
                            out_mod_reg <= '0;
                            in_done_reg <= 1'b0;
                        end
                        else if ((11'(out_col_reg) + 11'd1) >= eff_w)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 12'd1;
                            out_mod_reg <= out_mod_inc;
                        end
                        else
                            out_col_reg <= out_col_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // The user must issue configuration writes only while the block is idle; the block does not enforce it.
            if (cfg_we)
            begin
                case (cfg_index)
                    icf_pkg::CFG_RADIUS:
                    begin
                        radius_reg   <= cfg_data[1:0];
                        sum_pend_reg <= 1'b1;
                    end
                    icf_pkg::CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                    icf_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    icf_pkg::CFG_THREE:  three_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_c0     = out_c0_reg;
    assign out_c1     = out_c1_reg;
    assign out_c2     = out_c2_reg;
    assign frame_last = frame_last_reg;

    // A new result shows up only from the output loading state.
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output loading state");

    // The divider is never restarted while it is still working.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // The final pixel of a frame returns the output counters to the origin.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> (out_row_reg == '0 && out_col_reg == '0 && !in_done_reg))
        else $error("counters not cleared after the final pixel");

endmodule
